### hw/rtl/lzwd_pkg.sv
`default_nettype none
package lzwd_pkg;

	localparam int DictSize  = 4096;
	localparam int AddrBits  = $clog2(DictSize);
	localparam int SymBits   = 8;
	localparam int CodeBits  = 12;
	localparam int WidthBits = 4;
	localparam logic [WidthBits-1:0] InitWidth = WidthBits'(8);
	localparam logic [AddrBits-1:0]  LastRoot  = AddrBits'((1 << SymBits) - 1);
	localparam logic [AddrBits-1:0]  LastEntry = AddrBits'(DictSize - 1);

	typedef struct packed {
		logic                valid;
		logic [AddrBits-1:0] idx;
	} link_t;

	typedef struct packed {
		logic [SymBits-1:0] sym_byte;
		link_t              first_child;
		link_t              left_link;
		link_t              right_link;
	} node_t;

	localparam int NodeBits = $bits(node_t);

	typedef struct packed {
		logic                we;
		logic [AddrBits-1:0] waddr;
		node_t               wdata;
		logic                re;
		logic [AddrBits-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic                 found;
		logic [CodeBits-1:0]  code;
		logic                 inserted;
		logic [CodeBits-1:0]  new_code;
		logic [WidthBits-1:0] code_bits;
		logic                 table_full;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_PREFIX,
		ST_WALK,
		ST_MISS,
		ST_WR_NEW,
		ST_RESULT
	} state_t;

endpackage
`default_nettype wire

### hw/rtl/lzwd_ram.sv
`default_nettype none
module lzwd_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output      logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lzwd_ctrl.sv
`default_nettype none
module lzwd_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic                            in_has_prefix,
	input  wire logic [lzwd_pkg::CodeBits-1:0]   in_prefix,
	input  wire logic [lzwd_pkg::SymBits-1:0]    in_symbol,
	output      lzwd_pkg::ram_req_t              ram_req,
	input  wire lzwd_pkg::node_t                 ram_rdata,
	output      logic                            res_valid,
	input  wire logic                            res_ready,
	output      lzwd_pkg::result_t               res
);

	lzwd_pkg::state_t                     state_q, state_d;
	logic [lzwd_pkg::AddrBits-1:0]        clr_cnt_q, clr_cnt_d;
	logic [lzwd_pkg::AddrBits-1:0]        last_code_q, last_code_d;
	logic [lzwd_pkg::WidthBits-1:0]       width_q, width_d;
	logic [lzwd_pkg::SymBits-1:0]         sym_q, sym_d;
	logic [lzwd_pkg::AddrBits-1:0]        prefix_q, prefix_d;
	lzwd_pkg::node_t                      parent_q, parent_d;
	logic [lzwd_pkg::AddrBits-1:0]        parent_addr_q, parent_addr_d;
	logic [lzwd_pkg::AddrBits-1:0]        cur_addr_q, cur_addr_d;
	logic                                 have_prev_q, have_prev_d;
	logic                                 dir_right_q, dir_right_d;
	lzwd_pkg::result_t                    res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzwd_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			last_code_q <= lzwd_pkg::LastRoot;
			width_q     <= lzwd_pkg::InitWidth;
			have_prev_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_cnt_q   <= clr_cnt_d;
			last_code_q <= last_code_d;
			width_q     <= width_d;
			have_prev_q <= have_prev_d;
		end
	end

	always_ff @(posedge clk) begin
		sym_q         <= sym_d;
		prefix_q      <= prefix_d;
		parent_q      <= parent_d;
		parent_addr_q <= parent_addr_d;
		cur_addr_q    <= cur_addr_d;
		dir_right_q   <= dir_right_d;
		res_q         <= res_d;
	end

	always_comb begin
		logic [lzwd_pkg::AddrBits-1:0]  new_idx;
		logic [lzwd_pkg::WidthBits-1:0] new_width;
		lzwd_pkg::link_t                nxt;
		lzwd_pkg::node_t                upd;

		state_d       = state_q;
		clr_cnt_d     = clr_cnt_q;
		last_code_d   = last_code_q;
		width_d       = width_q;
		sym_d         = sym_q;
		prefix_d      = prefix_q;
		parent_d      = parent_q;
		parent_addr_d = parent_addr_q;
		cur_addr_d    = cur_addr_q;
		have_prev_d   = have_prev_q;
		dir_right_d   = dir_right_q;
		res_d         = res_q;
		ram_req       = '0;
		in_ready      = 1'b0;
		res_valid     = 1'b0;

		new_idx   = last_code_q + 1'b1;
		new_width = ((lzwd_pkg::AddrBits+1)'(new_idx) ==
			((lzwd_pkg::AddrBits+1)'(1) << width_q)) ? width_q + 1'b1 : width_q;
		nxt = ram_rdata.sym_byte < sym_q ? ram_rdata.right_link : ram_rdata.left_link;
		upd = parent_q;

		case (state_q)
			lzwd_pkg::ST_CLEAR: begin
				ram_req.we             = 1'b1;
				ram_req.waddr          = clr_cnt_q;
				ram_req.wdata          = '0;
				ram_req.wdata.sym_byte = clr_cnt_q[lzwd_pkg::SymBits-1:0];
				clr_cnt_d              = clr_cnt_q + 1'b1;
				if (clr_cnt_q == lzwd_pkg::LastEntry) begin
					state_d = lzwd_pkg::ST_IDLE;
				end
			end
			lzwd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					sym_d       = in_symbol;
					prefix_d    = lzwd_pkg::AddrBits'(in_prefix);
					have_prev_d = 1'b0;
					if (!in_has_prefix) begin
						res_d           = '0;
						res_d.found     = 1'b1;
						res_d.code      = lzwd_pkg::CodeBits'(in_symbol);
						res_d.code_bits = width_q;
						state_d         = lzwd_pkg::ST_RESULT;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = lzwd_pkg::AddrBits'(in_prefix);
						state_d       = lzwd_pkg::ST_RD_PREFIX;
					end
				end
			end
			lzwd_pkg::ST_RD_PREFIX: begin
				parent_d      = ram_rdata;
				parent_addr_d = prefix_q;
				if (ram_rdata.first_child.valid) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = ram_rdata.first_child.idx;
					cur_addr_d    = ram_rdata.first_child.idx;
					state_d       = lzwd_pkg::ST_WALK;
				end else begin
					state_d = lzwd_pkg::ST_MISS;
				end
			end
			lzwd_pkg::ST_WALK: begin
				if (ram_rdata.sym_byte == sym_q) begin
					res_d           = '0;
					res_d.found     = 1'b1;
					res_d.code      = lzwd_pkg::CodeBits'(cur_addr_q);
					res_d.code_bits = width_q;
					state_d         = lzwd_pkg::ST_RESULT;
				end else begin
					parent_d      = ram_rdata;
					parent_addr_d = cur_addr_q;
					have_prev_d   = 1'b1;
					dir_right_d   = ram_rdata.sym_byte < sym_q;
					if (nxt.valid) begin
						ram_req.re    = 1'b1;
						ram_req.raddr = nxt.idx;
						cur_addr_d    = nxt.idx;
					end else begin
						state_d = lzwd_pkg::ST_MISS;
					end
				end
			end
			lzwd_pkg::ST_MISS: begin
				res_d = '0;
				if (last_code_q == lzwd_pkg::LastEntry) begin
					res_d.table_full = 1'b1;
					res_d.code_bits  = width_q;
					state_d          = lzwd_pkg::ST_RESULT;
				end else begin
					last_code_d     = new_idx;
					width_d         = new_width;
					res_d.inserted  = 1'b1;
					res_d.new_code  = lzwd_pkg::CodeBits'(new_idx);
					res_d.code_bits = new_width;
					ram_req.we      = 1'b1;
					if (!have_prev_q && prefix_q == new_idx) begin
						// new entry is its own first child
						ram_req.waddr                   = new_idx;
						ram_req.wdata                   = '0;
						ram_req.wdata.sym_byte          = sym_q;
						ram_req.wdata.first_child.valid = 1'b1;
						ram_req.wdata.first_child.idx   = new_idx;
						state_d                         = lzwd_pkg::ST_RESULT;
					end else begin
						if (!have_prev_q) begin
							upd.first_child = '{valid: 1'b1, idx: new_idx};
						end else if (dir_right_q) begin
							upd.right_link = '{valid: 1'b1, idx: new_idx};
						end else begin
							upd.left_link = '{valid: 1'b1, idx: new_idx};
						end
						ram_req.waddr = parent_addr_q;
						ram_req.wdata = upd;
						state_d       = lzwd_pkg::ST_WR_NEW;
					end
				end
			end
			lzwd_pkg::ST_WR_NEW: begin
				ram_req.we             = 1'b1;
				ram_req.waddr          = last_code_q;
				ram_req.wdata          = '0;
				ram_req.wdata.sym_byte = sym_q;
				state_d                = lzwd_pkg::ST_RESULT;
			end
			lzwd_pkg::ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = lzwd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lzwd_pkg::ST_IDLE;
			end
		endcase
	end

	assign res = res_q;

endmodule
`default_nettype wire

### hw/rtl/lzw_dictionary_search_insert_core.sv
// channel   dir  tdata                                          tuser
// s_axis    in   prefix_code[11:0] symbol[19:12]                has_prefix[0]
// m_axis    out  code[11:0] new_code[23:12] code_bits[27:24]    found[0] inserted[1] table_full[2]
//
// one request at a time; a lone byte's result is registered, then moved to the output register
// a prefixed request reads the prefix node and walks its child tree to a hit or a miss; a miss
// on a full table gives table_full, a self-linked insert writes the new entry, other inserts write
// the parent link, then the new entry; the walk reads one tree node per cycle (single read port)
// after reset a clearing pass writes all 4096 node entries with tready low
// the result register holds a finished result while the next request is accepted
`default_nettype none
module lzw_dictionary_search_insert_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // prefix_code, symbol, zero pad
	input  wire logic [0:0]  s_axis_tuser,   // has_prefix
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata,   // code, new_code, code_bits, zero pad
	output      logic [2:0]  m_axis_tuser    // found, inserted, table_full
);

	lzwd_pkg::ram_req_t ram_req;
	lzwd_pkg::node_t    ram_rdata;
	logic               res_valid;
	logic               res_ready;
	lzwd_pkg::result_t  res;
	lzwd_pkg::result_t  out_q;
	logic               out_valid_q;

	lzwd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_has_prefix (s_axis_tuser[0]),
		.in_prefix     (s_axis_tdata[11:0]),
		.in_symbol     (s_axis_tdata[19:12]),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	lzwd_ram #(
		.Width (lzwd_pkg::NodeBits),
		.Depth (lzwd_pkg::DictSize)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_q.code_bits, out_q.new_code, out_q.code};
	assign m_axis_tuser  = {out_q.table_full, out_q.inserted, out_q.found};

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	a_insert_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.inserted |-> !res.found && !res.table_full)
		else $error("insert flagged together with hit or full");

	a_new_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.inserted |-> res.new_code > lzwd_pkg::CodeBits'(lzwd_pkg::LastRoot))
		else $error("new code overlaps a root entry");

	a_code_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.code_bits >= lzwd_pkg::InitWidth
			&& res.code_bits <= lzwd_pkg::WidthBits'(lzwd_pkg::CodeBits))
		else $error("code width out of range");
`endif

endmodule
`default_nettype wire
